// ----- src/cia_pkg.sv -----
// complex integer alu: shared package
// op codes and default sizes; no dependencies
`timescale 1ns / 1ps

package cia_pkg;

  localparam int unsigned WIDTH_DEF  = 16;
  localparam int unsigned IO_W       = 16;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_ADDR = 3'd5,
    OP_SUBR = 3'd6,
    OP_DIVR = 3'd7
  } op_t;

endpackage

// ----- src/cia_front.sv -----
// complex integer alu: front stage, takes items and sign-extends operands to WIDTH
// depends on cia_pkg
`timescale 1ns / 1ps

module cia_front
  import cia_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_op,
  input  logic [IO_W-1:0]         in_a_re,
  input  logic [IO_W-1:0]         in_a_im,
  input  logic [IO_W-1:0]         in_b_re,
  input  logic [IO_W-1:0]         in_b_im,
  output logic                    q_valid,
  input  logic                    q_ready,
  output op_t                     q_op,
  output logic signed [WIDTH-1:0] q_a_re,
  output logic signed [WIDTH-1:0] q_a_im,
  output logic signed [WIDTH-1:0] q_b_re,
  output logic signed [WIDTH-1:0] q_b_im
);

  localparam int unsigned IW = (WIDTH < IO_W) ? WIDTH : IO_W;

  logic                    valid_r;
  op_t                     op_r;
  logic signed [WIDTH-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic                    take;

  assign in_ready = !valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= op_t'(in_op);
      a_re_r <= WIDTH'($signed(in_a_re[IW-1:0]));
      a_im_r <= WIDTH'($signed(in_a_im[IW-1:0]));
      b_re_r <= WIDTH'($signed(in_b_re[IW-1:0]));
      b_im_r <= WIDTH'($signed(in_b_im[IW-1:0]));
    end
  end

  assign q_valid = valid_r;
  assign q_op    = op_r;
  assign q_a_re  = a_re_r;
  assign q_a_im  = a_im_r;
  assign q_b_re  = b_re_r;
  assign q_b_im  = b_im_r;

endmodule

// ----- src/cia_fifo.sv -----
// complex integer alu: small queue between front and back
// depends on cia_pkg
`timescale 1ns / 1ps

module cia_fifo
  import cia_pkg::*;
#(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r, wptr_nxt, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r < (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/cia_back.sv -----
// complex integer alu: back pipeline, products, operand prep, divider stages, output register
// depends on cia_pkg
`timescale 1ns / 1ps

module cia_back
  import cia_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  op_t                     op,
  input  logic signed [WIDTH-1:0] a_re,
  input  logic signed [WIDTH-1:0] a_im,
  input  logic signed [WIDTH-1:0] b_re,
  input  logic signed [WIDTH-1:0] b_im,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WIDTH-1:0]        res_re,
  output logic [WIDTH-1:0]        res_im,
  output logic                    div_zero
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned QB = WIDTH + 1;
  localparam int unsigned RW = PW + QB;

  logic adv;

  // product stage
  logic                    p_v_r;
  op_t                     p_op_r;
  logic signed [WIDTH-1:0] p_ar_r, p_ai_r, p_br_r, p_bi_r;
  logic signed [PW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_dd_r;

  // prep results
  logic                    s_div, s_dz, s_den_neg;
  logic [WIDTH-1:0]        s_res_re, s_res_im;
  logic signed [PW:0]      s_nr, s_ni, s_bx;
  logic [PW-1:0]           s_den;

  // divider pipeline, entry 0 is the prep register
  logic                    d_v_r      [QB+1];
  logic                    d_div_r    [QB+1];
  logic                    d_dz_r     [QB+1];
  logic                    d_neg_re_r [QB+1];
  logic                    d_neg_im_r [QB+1];
  logic [WIDTH-1:0]        d_res_re_r [QB+1];
  logic [WIDTH-1:0]        d_res_im_r [QB+1];
  logic [PW-1:0]           d_den_r    [QB+1];
  logic [PW-1:0]           d_rem_re_r [QB+1];
  logic [PW-1:0]           d_rem_im_r [QB+1];
  logic [QB-1:0]           d_q_re_r   [QB+1];
  logic [QB-1:0]           d_q_im_r   [QB+1];

  logic [PW-1:0]           x_rem_re   [QB];
  logic [PW-1:0]           x_rem_im   [QB];
  logic [QB-1:0]           x_q_re     [QB];
  logic [QB-1:0]           x_q_im     [QB];

  logic                    out_valid_r, out_dz_r;
  logic [WIDTH-1:0]        out_re_r, out_im_r, o_re_nxt, o_im_nxt;
  logic [QB-1:0]           o_qre, o_qim;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_op_r <= op;
      p_ar_r <= a_re;
      p_ai_r <= a_im;
      p_br_r <= b_re;
      p_bi_r <= b_im;
      p_rr_r <= a_re * b_re;
      p_ii_r <= a_im * b_im;
      p_ri_r <= a_re * b_im;
      p_ir_r <= a_im * b_re;
      p_bb_r <= b_re * b_re;
      p_dd_r <= b_im * b_im;
    end
  end

  always_comb begin
    s_div     = 1'b0;
    s_den_neg = 1'b0;
    s_res_re  = '0;
    s_res_im  = '0;
    s_nr      = '0;
    s_ni      = '0;
    s_den     = '0;
    s_bx      = (PW+1)'(p_br_r);
    unique case (p_op_r)
      OP_ADD: begin
        s_res_re = WIDTH'(p_ar_r + p_br_r);
        s_res_im = WIDTH'(p_ai_r + p_bi_r);
      end
      OP_SUB: begin
        s_res_re = WIDTH'(p_ar_r - p_br_r);
        s_res_im = WIDTH'(p_ai_r - p_bi_r);
      end
      OP_MUL: begin
        s_res_re = WIDTH'(p_rr_r - p_ii_r);
        s_res_im = WIDTH'(p_ri_r + p_ir_r);
      end
      OP_DIV: begin
        s_div = 1'b1;
        s_nr  = (PW+1)'(p_rr_r) + (PW+1)'(p_ii_r);
        s_ni  = (PW+1)'(p_ir_r) - (PW+1)'(p_ri_r);
        s_den = $unsigned(p_bb_r) + $unsigned(p_dd_r);
      end
      OP_CONJ: begin
        s_res_re = p_ar_r;
        s_res_im = WIDTH'(-p_ai_r);
      end
      OP_ADDR: begin
        s_res_re = WIDTH'(p_ar_r + p_br_r);
        s_res_im = p_ai_r;
      end
      OP_SUBR: begin
        s_res_re = WIDTH'(p_ar_r - p_br_r);
        s_res_im = p_ai_r;
      end
      OP_DIVR: begin
        s_div     = 1'b1;
        s_nr      = (PW+1)'(p_ar_r);
        s_ni      = (PW+1)'(p_ai_r);
        s_den_neg = p_br_r[WIDTH-1];
        s_den     = PW'(s_den_neg ? -s_bx : s_bx);
      end
      default: begin
        s_div = 1'b0;
      end
    endcase
    s_dz = s_div && (s_den == '0);
  end

  // one quotient bit per stage, msb first
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      x_rem_re[k] = d_rem_re_r[k];
      x_rem_im[k] = d_rem_im_r[k];
      x_q_re[k]   = d_q_re_r[k];
      x_q_im[k]   = d_q_im_r[k];
      if (RW'(d_rem_re_r[k]) >= (RW'(d_den_r[k]) << (QB - 1 - k))) begin
        x_rem_re[k]           = PW'(RW'(d_rem_re_r[k]) - (RW'(d_den_r[k]) << (QB - 1 - k)));
        x_q_re[k][QB - 1 - k] = 1'b1;
      end
      if (RW'(d_rem_im_r[k]) >= (RW'(d_den_r[k]) << (QB - 1 - k))) begin
        x_rem_im[k]           = PW'(RW'(d_rem_im_r[k]) - (RW'(d_den_r[k]) << (QB - 1 - k)));
        x_q_im[k][QB - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_div_r[0]    <= s_div;
      d_dz_r[0]     <= s_dz;
      d_neg_re_r[0] <= s_nr[PW] ^ s_den_neg;
      d_neg_im_r[0] <= s_ni[PW] ^ s_den_neg;
      d_res_re_r[0] <= s_res_re;
      d_res_im_r[0] <= s_res_im;
      d_den_r[0]    <= s_den;
      d_rem_re_r[0] <= PW'(s_nr[PW] ? -s_nr : s_nr);
      d_rem_im_r[0] <= PW'(s_ni[PW] ? -s_ni : s_ni);
      d_q_re_r[0]   <= '0;
      d_q_im_r[0]   <= '0;
      for (int k = 0; k < QB; k++) begin
        d_div_r[k+1]    <= d_div_r[k];
        d_dz_r[k+1]     <= d_dz_r[k];
        d_neg_re_r[k+1] <= d_neg_re_r[k];
        d_neg_im_r[k+1] <= d_neg_im_r[k];
        d_res_re_r[k+1] <= d_res_re_r[k];
        d_res_im_r[k+1] <= d_res_im_r[k];
        d_den_r[k+1]    <= d_den_r[k];
        d_rem_re_r[k+1] <= x_rem_re[k];
        d_rem_im_r[k+1] <= x_rem_im[k];
        d_q_re_r[k+1]   <= x_q_re[k];
        d_q_im_r[k+1]   <= x_q_im[k];
      end
      out_re_r <= o_re_nxt;
      out_im_r <= o_im_nxt;
      out_dz_r <= d_dz_r[QB];
    end
  end

  always_comb begin
    o_qre    = d_neg_re_r[QB] ? -d_q_re_r[QB] : d_q_re_r[QB];
    o_qim    = d_neg_im_r[QB] ? -d_q_im_r[QB] : d_q_im_r[QB];
    o_re_nxt = d_res_re_r[QB];
    o_im_nxt = d_res_im_r[QB];
    if (d_dz_r[QB]) begin
      o_re_nxt = '0;
      o_im_nxt = '0;
    end else if (d_div_r[QB]) begin
      o_re_nxt = o_qre[WIDTH-1:0];
      o_im_nxt = o_qim[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        d_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      p_v_r       <= in_valid;
      d_v_r[0]    <= p_v_r;
      for (int k = 0; k < QB; k++) begin
        d_v_r[k+1] <= d_v_r[k];
      end
      out_valid_r <= d_v_r[QB];
    end
  end

  assign out_valid = out_valid_r;
  assign res_re    = out_re_r;
  assign res_im    = out_im_r;
  assign div_zero  = out_dz_r;

endmodule

// ----- src/complex_integer_alu_top.sv -----
// complex integer alu: top level
// depends on cia_pkg, cia_front, cia_fifo, cia_back
//
// usage:
//   input channel in_valid/in_ready carries in_op and the operands in_a_re, in_a_im,
//   in_b_re, in_b_im; result channel out_valid/out_ready carries out_res_re,
//   out_res_im and out_div_zero, one result item per input item, in order.
//   ops: add, sub, mul, complex div, conjugate of a, add/sub/div by real scalar b_re.
//   stages from acceptance to out_valid: front register loads at acceptance, then
//   queue, product stage, prep stage, one divider stage per quotient bit
//   (WIDTH + 1 of them), output register.
//   throughput: one item per cycle when not stalled; every op runs down the same pipeline.
//   a stalled receiver freezes the back pipeline; the two-entry queue and the
//   front register keep taking items until they fill, then in_ready drops.
//   reset (rst_n low, synchronous) empties every stage; no other state is kept.
//   zero divisor gives a zero result with out_div_zero set.
`timescale 1ns / 1ps

module complex_integer_alu_top
  import cia_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_op,
  input  logic [IO_W-1:0] in_a_re,
  input  logic [IO_W-1:0] in_a_im,
  input  logic [IO_W-1:0] in_b_re,
  input  logic [IO_W-1:0] in_b_im,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [IO_W-1:0] out_res_re,
  output logic [IO_W-1:0] out_res_im,
  output logic            out_div_zero
);

  localparam int unsigned DW = 3 + 4 * WIDTH;
  localparam int unsigned OW = (WIDTH < IO_W) ? WIDTH : IO_W;

  logic                    f_valid, f_ready, b_valid, b_ready;
  op_t                     f_op;
  logic signed [WIDTH-1:0] f_a_re, f_a_im, f_b_re, f_b_im;
  logic [DW-1:0]           f_data, b_data;
  logic [WIDTH-1:0]        r_re, r_im;

  cia_front #(.WIDTH(WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_op     (f_op),
    .q_a_re   (f_a_re),
    .q_a_im   (f_a_im),
    .q_b_re   (f_b_re),
    .q_b_im   (f_b_im)
  );

  assign f_data = {f_op, f_a_re, f_a_im, f_b_re, f_b_im};

  cia_fifo #(.DW(DW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  cia_back #(.WIDTH(WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .op        (op_t'(b_data[DW-1 -: 3])),
    .a_re      ($signed(b_data[4*WIDTH-1 -: WIDTH])),
    .a_im      ($signed(b_data[3*WIDTH-1 -: WIDTH])),
    .b_re      ($signed(b_data[2*WIDTH-1 -: WIDTH])),
    .b_im      ($signed(b_data[WIDTH-1:0])),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_re    (r_re),
    .res_im    (r_im),
    .div_zero  (out_div_zero)
  );

  assign out_res_re = IO_W'($signed(r_re[OW-1:0]));
  assign out_res_im = IO_W'($signed(r_im[OW-1:0]));

endmodule
